### rtl/core/sos_pkg.sv
// set_of_stacks package: beat types, command and status codes
`timescale 1ns / 1ps

package sos_pkg;

	localparam int CAP_REG_W   = 5;
	localparam int CAP_RESET   = 16;
	localparam int VALUE_W     = 32;
	localparam int STACK_IDX_W = 3;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_POP_AT = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SET_EMPTY   = 3'd1,
		ST_BAD_INDEX   = 3'd2,
		ST_STACK_EMPTY = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [VALUE_W-1:0] push_value;
		logic [STACK_IDX_W-1:0]   stack_index;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] pop_value;
		status_t                  status;
		logic                     set_empty;
	} rsp_t;

endpackage

### rtl/core/sos_ram.sv
// generic single-port-write, registered-read RAM
`timescale 1ns / 1ps

module sos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/set_of_stacks.sv
// set_of_stacks top level: a growing row of bounded stacks held in one RAM
//
// Request channel req (valid/ready) carries one command beat: push a value,
// pop the last stack, or pop a chosen stack. Every request beat yields
// exactly one response beat on rsp (valid/ready) with the popped value,
// a status code and a flag that no stack remains in use.
// cfg_we/cfg_wdata set the per-stack capacity; write it only while idle.
// A request is decoded against the fill counts in the accept cycle; a push
// writes the RAM then, a pop issues the RAM read then. The read data and
// status wait in the read stage (RAM read register and info_s1) and move
// into the output register once it is free, which raises rsp_valid.
// Throughput is one beat per cycle while rsp does not stall: the RAM is used
// once per request and counts are updated in the accept cycle.
// When rsp stalls, one result waits in the output register and one in the
// read stage; req_ready drops only when both are full.
// Reset empties all stacks and sets the capacity to 16; the element RAM
// needs no clearing since the fill counts guard every read.
`timescale 1ns / 1ps

module set_of_stacks
	import sos_pkg::*;
#(
	parameter int MAX_STACKS   = 8,
	parameter int MAX_CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_REG_W-1:0] cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	localparam int SW    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int SCW   = $clog2(MAX_STACKS + 1);
	localparam int CW    = $clog2(MAX_CAPACITY + 1);
	localparam int DEPTH = MAX_STACKS * MAX_CAPACITY;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		status_t status;
		logic    set_empty;
		logic    take;
	} s1_t;

	logic [CAP_REG_W-1:0] cap_q;
	logic [CW-1:0]        cnt_q [MAX_STACKS];
	logic [SCW-1:0]       siu_q;

	logic                 valid_s1;
	s1_t                  info_s1;
	logic                 s1_move;
	logic                 acc;

	logic [CW-1:0]        cap_eff;
	logic [SW-1:0]        last_idx;
	logic [SW-1:0]        idx_w;
	logic [SW-1:0]        rd_idx;
	logic [CW-1:0]        cnt_rd;
	logic                 need_new;
	logic [SW-1:0]        wr_stack;
	logic [CW-1:0]        wr_cnt;
	logic                 cnt_we;
	logic [CW-1:0]        cnt_wr_val;
	logic [SW-1:0]        cnt_wr_idx;
	logic [SCW-1:0]       siu_nxt;
	status_t              st;
	logic                 take;
	logic                 ram_we;
	logic                 ram_re;
	logic [AW-1:0]        ram_addr;
	logic [VALUE_W-1:0]   ram_rdata;

	// capacity clamp
	always_comb begin
		logic [31:0] c;
		c = (cap_q == '0) ? 32'd1 : 32'(cap_q);
		if (c > 32'(MAX_CAPACITY)) begin
			c = 32'(MAX_CAPACITY);
		end
		cap_eff = CW'(c);
	end

	assign acc       = req_valid && req_ready;
	assign s1_move   = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || s1_move;

	assign last_idx = SW'(siu_q - 1'b1);
	assign idx_w    = SW'(req.stack_index);
	assign rd_idx   = (req.cmd == CMD_POP_AT) ? idx_w : last_idx;
	assign cnt_rd   = cnt_q[rd_idx];
	assign need_new = (siu_q == '0) || (cnt_rd >= cap_eff);

	always_comb begin
		st         = ST_OK;
		take       = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		cnt_we     = 1'b0;
		cnt_wr_idx = rd_idx;
		cnt_wr_val = cnt_rd - 1'b1;
		siu_nxt    = siu_q;
		wr_stack   = need_new ? SW'(siu_q) : last_idx;
		wr_cnt     = need_new ? '0 : cnt_rd;
		ram_addr   = AW'(rd_idx) * AW'(MAX_CAPACITY) + AW'(cnt_rd - 1'b1);
		unique case (req.cmd)
			CMD_PUSH: begin
				ram_addr = AW'(wr_stack) * AW'(MAX_CAPACITY) + AW'(wr_cnt);
				if (need_new && siu_q == SCW'(MAX_STACKS)) begin
					st = ST_FULL;
				end else begin
					ram_we     = 1'b1;
					cnt_we     = 1'b1;
					cnt_wr_idx = wr_stack;
					cnt_wr_val = wr_cnt + 1'b1;
					siu_nxt    = siu_q + SCW'(need_new);
				end
			end
			CMD_POP: begin
				if (siu_q == '0) begin
					st = ST_SET_EMPTY;
				end else if (cnt_rd == '0) begin
					st = ST_STACK_EMPTY;
				end else begin
					take   = 1'b1;
					ram_re = 1'b1;
					cnt_we = 1'b1;
					if (cnt_rd == CW'(1)) begin
						siu_nxt = siu_q - 1'b1;
					end
				end
			end
			CMD_POP_AT: begin
				if ({29'd0, req.stack_index} >= 32'(siu_q)) begin
					st = ST_BAD_INDEX;
				end else if (cnt_rd == '0) begin
					st = ST_STACK_EMPTY;
				end else begin
					take   = 1'b1;
					ram_re = 1'b1;
					cnt_we = 1'b1;
					if (cnt_rd == CW'(1) && rd_idx == last_idx) begin
						siu_nxt = siu_q - 1'b1;
					end
				end
			end
			CMD_NONE: begin
				st = ST_OK;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	sos_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (acc && ram_we),
		.waddr(ram_addr),
		.wdata(req.push_value),
		.re   (acc && ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_REG_W'(CAP_RESET);
			siu_q <= '0;
			for (int i = 0; i < MAX_STACKS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (acc) begin
				siu_q <= siu_nxt;
				if (cnt_we) begin
					cnt_q[cnt_wr_idx] <= cnt_wr_val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			info_s1.status    <= st;
			info_s1.set_empty <= (siu_nxt == '0);
			info_s1.take      <= take;
		end
		if (s1_move) begin
			rsp.pop_value <= info_s1.take ? ram_rdata : '0;
			rsp.status    <= info_s1.status;
			rsp.set_empty <= info_s1.set_empty;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(siu_q) <= MAX_STACKS)
	else $error("stack count above maximum");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
	else $error("ram read and write in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.pop_value == '0)
	else $error("error response carries a value");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (siu_q == $past(siu_q)) || (siu_q == $past(siu_q) + 1'b1) ||
			(siu_q == $past(siu_q) - 1'b1))
	else $error("stack count moved by more than one");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(info_s1))
	else $error("stalled read stage lost its result");

endmodule

### dv/set_of_stacks_test.sv
// set_of_stacks testbench: directed table and random command beats checked against a stack predictor
`timescale 1ns / 1ps

module set_of_stacks_test;
	import sos_pkg::*;

	localparam int STACK_N     = 8;
	localparam int CAP_MAX     = 16;
	localparam int SCRIPT_LEN  = 28;
	localparam int PHASE_ITEMS = 180;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		bit                   is_cfg;
		logic [CAP_REG_W-1:0] cap;
		req_t                 item;
		bit                   fixed;
		rsp_t                 want;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CAP_REG_W-1:0] cfg_wdata = '0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;

	// stack model state
	logic signed [VALUE_W-1:0] word_mem [STACK_N][CAP_MAX];
	int unsigned               fill_cnt [STACK_N];
	int unsigned               n_used = 0;
	logic [CAP_REG_W-1:0]      cap_reg = CAP_REG_W'(CAP_RESET);

	rsp_t expected_rsps [$];
	int   mismatch_cnt = 0;
	int   cycle_cnt = 0;
	int   send_idle = 10;
	int   recv_idle = 88;

	logic [CAP_REG_W-1:0] phase_caps [8] = '{5'd1, 5'd16, 5'd0, 5'd3, 5'd31, 5'd2, 5'd9, 5'd5};

	script_row_t script [SCRIPT_LEN] = '{
		'{1'b0, 5'd0, '{CMD_POP,    32'sh0,        3'd0}, 1'b1, '{32'sh0, ST_SET_EMPTY, 1'b1}},
		'{1'b0, 5'd0, '{CMD_POP_AT, 32'sh0,        3'd7}, 1'b1, '{32'sh0, ST_BAD_INDEX, 1'b1}},
		'{1'b0, 5'd0, '{CMD_NONE,   32'shffffffff, 3'd7}, 1'b1, '{32'sh0, ST_OK, 1'b1}},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh7fffffff, 3'd0}, 1'b1, '{32'sh0, ST_OK, 1'b0}},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh80000000, 3'd5}, 1'b1, '{32'sh0, ST_OK, 1'b0}},
		'{1'b0, 5'd0, '{CMD_POP_AT, 32'sh0,        3'd0}, 1'b1,
			'{32'sh80000000, ST_OK, 1'b0}},
		'{1'b0, 5'd0, '{CMD_POP_AT, 32'sh0,        3'd1}, 1'b1, '{32'sh0, ST_BAD_INDEX, 1'b0}},
		// zero capacity behaves as one
		'{1'b1, 5'd0, '{CMD_NONE,   32'sh0,        3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh00000001, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh55555555, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'shaaaaaaaa, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh12345678, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'shfedcba98, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh00000000, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'shffffffff, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh0f0f0f0f, 3'd0}, 1'b1, '{32'sh0, ST_FULL, 1'b0}},
		// empty a middle stack, then uncover it as last
		'{1'b0, 5'd0, '{CMD_POP_AT, 32'sh0,        3'd3}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_POP_AT, 32'sh0,        3'd3}, 1'b1, '{32'sh0, ST_STACK_EMPTY, 1'b0}},
		'{1'b0, 5'd0, '{CMD_POP,    32'sh0,        3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_POP,    32'sh0,        3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_POP,    32'sh0,        3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_POP,    32'sh0,        3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_POP,    32'sh0,        3'd0}, 1'b1, '{32'sh0, ST_STACK_EMPTY, 1'b0}},
		// capacity above the maximum clamps, then lowered while in use
		'{1'b1, 5'd31, '{CMD_NONE,  32'sh0,        3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh00000042, 3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh00000043, 3'd0}, 1'b0, '0},
		'{1'b1, 5'd2, '{CMD_NONE,   32'sh0,        3'd0}, 1'b0, '0},
		'{1'b0, 5'd0, '{CMD_PUSH,   32'sh00000044, 3'd0}, 1'b0, '0}
	};

	set_of_stacks #(
		.MAX_STACKS  (STACK_N),
		.MAX_CAPACITY(CAP_MAX)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #4 clk = ~clk;

	function automatic rsp_t apply_stack_op(req_t item);
		rsp_t        res;
		int unsigned cap;
		int unsigned top;
		bit          open_new;
		res = '0;
		res.status = ST_OK;
		cap = (cap_reg == 0) ? 1 : (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
		case (item.cmd)
			CMD_PUSH: begin
				open_new = (n_used == 0) || (fill_cnt[n_used - 1] >= cap);
				if (open_new && n_used >= STACK_N) begin
					res.status = ST_FULL;
				end else begin
					if (open_new) begin
						fill_cnt[n_used] = 0;
						n_used++;
					end
					top = n_used - 1;
					word_mem[top][fill_cnt[top]] = item.push_value;
					fill_cnt[top]++;
				end
			end
			CMD_POP: begin
				if (n_used == 0) begin
					res.status = ST_SET_EMPTY;
				end else begin
					top = n_used - 1;
					if (fill_cnt[top] == 0) begin
						res.status = ST_STACK_EMPTY;
					end else begin
						fill_cnt[top]--;
						res.pop_value = word_mem[top][fill_cnt[top]];
						if (fill_cnt[top] == 0)
							n_used--;
					end
				end
			end
			CMD_POP_AT: begin
				top = 32'(item.stack_index);
				if (top >= n_used) begin
					res.status = ST_BAD_INDEX;
				end else if (fill_cnt[top] == 0) begin
					res.status = ST_STACK_EMPTY;
				end else begin
					fill_cnt[top]--;
					res.pop_value = word_mem[top][fill_cnt[top]];
					if (fill_cnt[top] == 0 && top == n_used - 1)
						n_used--;
				end
			end
			default: begin
			end
		endcase
		res.set_empty = (n_used == 0);
		return res;
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_cnt++;
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	task automatic enqueue_expected(rsp_t exp_rsp);
		expected_rsps = {expected_rsps, exp_rsp};
	endtask

	task automatic check_rsp(rsp_t got);
		rsp_t want;
		if (expected_rsps.size() == 0) begin
			note_mismatch("response beat with none expected", got.pop_value, '0);
			return;
		end
		want = expected_rsps.pop_front();
		if (got.pop_value !== want.pop_value)
			note_mismatch("pop_value", got.pop_value, want.pop_value);
		if (got.status !== want.status)
			note_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.set_empty !== want.set_empty)
			note_mismatch("set_empty", 32'(got.set_empty), 32'(want.set_empty));
	endtask

	task automatic send_op(req_t item, bit fixed, rsp_t want);
		rsp_t predicted;
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		predicted = apply_stack_op(item);
		enqueue_expected(fixed ? want : predicted);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_REG_W-1:0] cap);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		cap_reg = cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// response side: check accepted beats, then randomize ready
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_rsp(rsp);
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		req_t item;
		int   fill_bias;
		foreach (fill_cnt[i])
			fill_cnt[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				wait_drained();
				write_capacity(script[i].cap);
			end else begin
				send_op(script[i].item, script[i].fixed, script[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			send_idle = (ph < 3) ? 10 : (ph < 6) ? 88 : 0;
			recv_idle = (ph < 3) ? 88 : (ph < 6) ? 10 : 0;
			wait_drained();
			write_capacity((ph == 6) ? 5'($urandom_range(0, 31)) : phase_caps[ph]);
			fill_bias = 50;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// alternate fill and drain stretches so the set grows and shrinks
				if (k % 45 == 0)
					fill_bias = $urandom_range(25, 85);
				if ($urandom_range(0, 99) < 4)
					item.cmd = CMD_NONE;
				else if ($urandom_range(0, 99) < fill_bias)
					item.cmd = CMD_PUSH;
				else if ($urandom_range(0, 1) == 1)
					item.cmd = CMD_POP;
				else
					item.cmd = CMD_POP_AT;
				item.push_value = ($urandom_range(0, 9) == 0) ?
					(32'h7fffffff + 32'($urandom_range(0, 1))) : 32'($urandom());
				item.stack_index = (n_used > 0 && $urandom_range(0, 3) != 0) ?
					3'($urandom_range(0, n_used - 1)) : 3'($urandom_range(0, 7));
				send_op(item, 1'b0, '0);
			end
		end

		wait_drained();
		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/core/sos_pkg.sv
rtl/core/sos_ram.sv
rtl/core/set_of_stacks.sv
dv/set_of_stacks_test.sv
